// ----- hdl/gpcs_pkg.sv -----
// ----------------------------------------------------------------------------
// gpcs_pkg: shared types and constants of the group pending command scheduler
// Holds the opcode and command code sets, the request and result beat
// structs, and the per-group pending state record.
// ----------------------------------------------------------------------------
package gpcs_pkg;

	// Number of lighting groups that hold pending state.
	localparam int GROUP_COUNT = 16;
	// Width of an index into the per-group state.
	localparam int GIDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

	typedef enum logic [3:0] {
		OP_SERVICE = 4'd0,
		OP_RMAX    = 4'd1,
		OP_OFF     = 4'd2,
		OP_LEVEL   = 4'd3,
		OP_STEPUP  = 4'd4,
		OP_UP      = 4'd5,
		OP_DOWN    = 4'd6,
		OP_TCUP    = 4'd7,
		OP_TCDOWN  = 4'd8,
		OP_SCENE   = 4'd9,
		OP_REST    = 4'd10,
		OP_RELIGHT = 4'd11,
		OP_INHIBIT = 4'd12,
		OP_QUERY   = 4'd13
	} op_t;

	typedef enum logic [3:0] {
		CMD_RMAX    = 4'd0,
		CMD_OFF     = 4'd1,
		CMD_LEVEL   = 4'd2,
		CMD_STEPUP  = 4'd3,
		CMD_UP      = 4'd4,
		CMD_DOWN    = 4'd5,
		CMD_TCUP    = 4'd6,
		CMD_TCDOWN  = 4'd7,
		CMD_SCENE   = 4'd8,
		CMD_REST    = 4'd9,
		CMD_RELIGHT = 4'd10,
		CMD_INHIBIT = 4'd11,
		CMD_QUERY   = 4'd12
	} code_t;

	// Request beat. The opcode is kept as raw bits so unused codes pass through.
	typedef struct packed {
		logic [3:0] opcode;
		logic [3:0] group;
		logic [7:0] level;
		logic [3:0] scene_number;
		logic [7:0] sensor_address;
		logic       from_light_regulator;
		logic       sink_ready;
	} req_t;

	// Result beat.
	typedef struct packed {
		logic       cmd_valid;
		logic [3:0] cmd_code;
		logic [3:0] cmd_group;
		logic [7:0] cmd_argument;
	} rsp_t;

	// Pending flags and repeat counts of one group.
	typedef struct packed {
		logic       rmax;
		logic       off;
		logic       lvl;
		logic       stepup;
		logic       up;
		logic       down;
		logic       tcup;
		logic       tcdown;
		logic       scene;
		logic [1:0] rest_cnt;
		logic [1:0] relight_cnt;
		logic [1:0] inhibit_cnt;
		logic       query;
	} grp_state_t;

	// Outcome of the priority pick over one group's pending state.
	typedef struct packed {
		logic  hit;
		code_t code;
	} sel_t;

endpackage

// ----- hdl/gpcs_select.sv -----
// ----------------------------------------------------------------------------
// gpcs_select: fixed-priority pick of a group's pending command
// Returns whether anything is pending and the code of the highest-priority
// entry, in the order recall max, off, level, step up, up, down, color
// temperature up and down, scene, rest, relight, inhibit, query.
// ----------------------------------------------------------------------------
module gpcs_select import gpcs_pkg::*; (
	input  grp_state_t ent,
	output sel_t       sel
);

	always_comb begin
		sel.hit  = 1'b1;
		sel.code = CMD_RMAX;
		if (ent.rmax) begin
			sel.code = CMD_RMAX;
		end else if (ent.off) begin
			sel.code = CMD_OFF;
		end else if (ent.lvl) begin
			sel.code = CMD_LEVEL;
		end else if (ent.stepup) begin
			sel.code = CMD_STEPUP;
		end else if (ent.up) begin
			sel.code = CMD_UP;
		end else if (ent.down) begin
			sel.code = CMD_DOWN;
		end else if (ent.tcup) begin
			sel.code = CMD_TCUP;
		end else if (ent.tcdown) begin
			sel.code = CMD_TCDOWN;
		end else if (ent.scene) begin
			sel.code = CMD_SCENE;
		end else if (ent.rest_cnt != 2'd0) begin
			sel.code = CMD_REST;
		end else if (ent.relight_cnt != 2'd0) begin
			sel.code = CMD_RELIGHT;
		end else if (ent.inhibit_cnt != 2'd0) begin
			sel.code = CMD_INHIBIT;
		end else if (ent.query) begin
			sel.code = CMD_QUERY;
		end else begin
			sel.hit = 1'b0;
		end
	end

endmodule

// ----- hdl/group_pending_command_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// group_pending_command_scheduler_top: per-group lighting command scheduler
// Posts lighting requests per group, cancels conflicting ones, and issues the
// highest-priority pending command of a group on a service beat.
// ----------------------------------------------------------------------------
// Usage
//   A request beat is taken at a rising edge with start high and busy low.
//   Its opcode either posts an action for one group or, for a service beat,
//   asks for that group's highest-priority pending command.
//   Every accepted beat yields exactly one result beat: done is high for one
//   cycle while result holds it. Only a service beat that finds something
//   pending with sink_ready set gives cmd_valid high; all other beats give
//   an all-zero result.
//   The beat is registered, then one pass of logic reads and writes the
//   addressed group's state and fills the result register.
//   Throughput is one beat per cycle: the state of a group is written at the
//   same edge that loads the next beat, so back-to-back beats to one group
//   see each other's updates.
//   Reset clears all pending flags and repeat counts at once; busy is high
//   during reset and for the first cycle after it. Level, scene and query
//   arguments hold no reset value and are read only behind their flags.
//   The receiver cannot stall: results are presented once and never held.
// ----------------------------------------------------------------------------
module group_pending_command_scheduler_top import gpcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	logic                accept;
	logic                busy_q;
	logic                valid_s1;
	req_t                req_s1;
	logic                done_q;
	rsp_t                rsp_q;
	rsp_t                rsp_d;

	grp_state_t          st_q [GROUP_COUNT];
	logic [7:0]          level_value_q [GROUP_COUNT];
	logic [3:0]          scene_value_q [GROUP_COUNT];
	logic [7:0]          query_addr_q  [GROUP_COUNT];

	logic [GIDX_W-1:0]   idx;
	logic                in_range;
	logic                wr_en;
	grp_state_t          ent;
	grp_state_t          ent_nxt;
	sel_t                sel;
	logic                issue;
	logic                lvl_blocked;
	logic                lvl_wr;
	logic                scene_wr;
	logic                query_wr;
	logic [7:0]          arg;

	logic [GROUP_COUNT-1:0] up_down_vec;
	logic [GROUP_COUNT-1:0] rest_grp_vec;

	// The block never needs to refuse a beat once out of reset.
	assign busy   = busy_q;
	assign accept = start && !busy_q;
	assign done   = done_q;
	assign result = rsp_q;

	// Handshake, input valid, done and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			rsp_q    <= '0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
			done_q   <= valid_s1;
			rsp_q    <= valid_s1 ? rsp_d : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= request;
		end
	end

	// Addressed group; groups past the populated range are ignored.
	assign idx      = GIDX_W'(req_s1.group);
	assign in_range = 32'(req_s1.group) < GROUP_COUNT;
	assign wr_en    = valid_s1 && in_range;
	assign ent      = st_q[idx];

	gpcs_select u_select (
		.ent (ent),
		.sel (sel)
	);

	assign issue       = (req_s1.opcode == OP_SERVICE) && sel.hit && req_s1.sink_ready;
	assign lvl_blocked = ent.up || ent.down || ent.rmax || ent.off;
	assign lvl_wr      = wr_en && (req_s1.opcode == OP_LEVEL)
		&& !(req_s1.from_light_regulator && lvl_blocked);
	assign scene_wr    = wr_en && (req_s1.opcode == OP_SCENE);
	assign query_wr    = wr_en && (req_s1.opcode == OP_QUERY);

	// Next state of the addressed group.
	always_comb begin
		ent_nxt = ent;
		case (req_s1.opcode)
			OP_SERVICE: begin
				if (issue) begin
					case (sel.code)
						CMD_RMAX:    ent_nxt.rmax = 1'b0;
						CMD_OFF:     ent_nxt.off = 1'b0;
						CMD_LEVEL:   ent_nxt.lvl = 1'b0;
						CMD_STEPUP:  ent_nxt.stepup = 1'b0;
						CMD_UP:      ent_nxt.up = 1'b0;
						CMD_DOWN:    ent_nxt.down = 1'b0;
						CMD_TCUP:    ent_nxt.tcup = 1'b0;
						CMD_TCDOWN:  ent_nxt.tcdown = 1'b0;
						CMD_SCENE:   ent_nxt.scene = 1'b0;
						CMD_REST:    ent_nxt.rest_cnt = ent.rest_cnt - 2'd1;
						CMD_RELIGHT: ent_nxt.relight_cnt = ent.relight_cnt - 2'd1;
						CMD_INHIBIT: ent_nxt.inhibit_cnt = ent.inhibit_cnt - 2'd1;
						CMD_QUERY:   ent_nxt.query = 1'b0;
						default: ;
					endcase
				end
			end
			OP_RMAX: begin
				ent_nxt.up    = 1'b0;
				ent_nxt.down  = 1'b0;
				ent_nxt.lvl   = 1'b0;
				ent_nxt.scene = 1'b0;
				ent_nxt.off   = 1'b0;
				ent_nxt.rmax  = 1'b1;
			end
			OP_OFF: begin
				ent_nxt.up    = 1'b0;
				ent_nxt.down  = 1'b0;
				ent_nxt.lvl   = 1'b0;
				ent_nxt.scene = 1'b0;
				ent_nxt.rmax  = 1'b0;
				ent_nxt.off   = 1'b1;
			end
			OP_LEVEL: begin
				// A regulator level only adds itself; a direct level also
				// cancels motion, scene, recall max and off.
				if (!req_s1.from_light_regulator) begin
					ent_nxt.up    = 1'b0;
					ent_nxt.down  = 1'b0;
					ent_nxt.scene = 1'b0;
					ent_nxt.rmax  = 1'b0;
					ent_nxt.off   = 1'b0;
				end
				if (lvl_wr) begin
					ent_nxt.lvl = 1'b1;
				end
			end
			OP_STEPUP: ent_nxt.stepup = 1'b1;
			OP_UP: begin
				ent_nxt.down = 1'b0;
				ent_nxt.up   = 1'b1;
			end
			OP_DOWN: begin
				ent_nxt.up   = 1'b0;
				ent_nxt.down = 1'b1;
			end
			OP_TCUP: begin
				ent_nxt.tcdown = 1'b0;
				ent_nxt.tcup   = 1'b1;
			end
			OP_TCDOWN: begin
				ent_nxt.tcup   = 1'b0;
				ent_nxt.tcdown = 1'b1;
			end
			OP_SCENE: ent_nxt.scene = 1'b1;
			OP_REST: begin
				ent_nxt.rest_cnt    = 2'd2;
				ent_nxt.relight_cnt = 2'd0;
				ent_nxt.inhibit_cnt = 2'd0;
			end
			OP_RELIGHT: begin
				ent_nxt.rest_cnt    = 2'd0;
				ent_nxt.relight_cnt = 2'd2;
				ent_nxt.inhibit_cnt = 2'd0;
			end
			OP_INHIBIT: begin
				ent_nxt.rest_cnt    = 2'd0;
				ent_nxt.relight_cnt = 2'd0;
				ent_nxt.inhibit_cnt = 2'd2;
			end
			OP_QUERY: ent_nxt.query = 1'b1;
			default: ;
		endcase
	end

	// Argument that goes with the issued command.
	always_comb begin
		case (sel.code)
			CMD_LEVEL: arg = level_value_q[idx];
			CMD_SCENE: arg = {4'd0, scene_value_q[idx]};
			CMD_QUERY: arg = query_addr_q[idx];
			default:   arg = 8'd0;
		endcase
	end

	always_comb begin
		rsp_d = '0;
		if (in_range && issue) begin
			rsp_d.cmd_valid    = 1'b1;
			rsp_d.cmd_code     = sel.code;
			rsp_d.cmd_group    = req_s1.group;
			rsp_d.cmd_argument = arg;
		end
	end

	// Pending flags and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GROUP_COUNT; i++) begin
				st_q[i] <= '0;
			end
		end else if (wr_en) begin
			st_q[idx] <= ent_nxt;
		end
	end

	// Command arguments, valid only while their flag is set.
	always_ff @(posedge clk) begin
		if (lvl_wr) begin
			level_value_q[idx] <= req_s1.level;
		end
		if (scene_wr) begin
			scene_value_q[idx] <= req_s1.scene_number;
		end
		if (query_wr) begin
			query_addr_q[idx] <= req_s1.sensor_address;
		end
	end

	// Per-group conflict views for checking.
	always_comb begin
		for (int i = 0; i < GROUP_COUNT; i++) begin
			up_down_vec[i]  = st_q[i].up && st_q[i].down;
			rest_grp_vec[i] = $countones({st_q[i].rest_cnt != 2'd0,
				st_q[i].relight_cnt != 2'd0, st_q[i].inhibit_cnt != 2'd0}) > 1;
		end
	end

`ifndef ASSERT_OFF
	// Every accepted beat gives a result, through the input valid and done registers.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted beat produced no result");

	// An issued command only appears on a result beat.
	a_valid_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.cmd_valid |-> done)
		else $error("command issued outside a result beat");

	// Up and down cancel each other in every group.
	a_up_down_excl: assert property (@(posedge clk) disable iff (!arst_n)
		up_down_vec == '0)
		else $error("up and down pending together");

	// At most one of rest, relight and inhibit is pending in a group.
	a_rest_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rest_grp_vec == '0)
		else $error("rest, relight or inhibit pending together");
`endif

endmodule

// ----- sim/gpcs_scoreboard.sv -----
// ----------------------------------------------------------------------------
// gpcs_scoreboard: result predictor and comparator for the command scheduler
// Watches the request and result channels of the scheduler, keeps its own
// copy of the per-group pending state, predicts the result of every accepted
// request beat and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module gpcs_scoreboard import gpcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t request,
	input  logic done,
	input  rsp_t result,
	output int   mismatches,
	output int   outstanding
);

	localparam int REPORT_LIMIT = 10;

	grp_state_t pend [GROUP_COUNT];
	logic [7:0] level_arg [GROUP_COUNT];
	logic [3:0] scene_arg [GROUP_COUNT];
	logic [7:0] query_arg [GROUP_COUNT];

	rsp_t cmd_q [$];
	rsp_t want;
	int   fails;

	// Off, recall-max and a direct level all drop queued motion, level and scene.
	function automatic void drop_motion(int g);
		pend[g].up = 1'b0;
		pend[g].down = 1'b0;
		pend[g].lvl = 1'b0;
		pend[g].scene = 1'b0;
	endfunction

	// Applies one request beat to the pending state and returns the result beat.
	function automatic rsp_t schedule(req_t r);
		rsp_t       cmd;
		int         g;
		code_t      code;
		logic [7:0] arg;
		logic       hit;
		cmd = '0;
		g = r.group;
		code = CMD_RMAX;
		arg = '0;
		hit = 1'b1;
		if (g >= GROUP_COUNT)
			return cmd;
		case (r.opcode)
			OP_SERVICE: begin
				if (pend[g].rmax) code = CMD_RMAX;
				else if (pend[g].off) code = CMD_OFF;
				else if (pend[g].lvl) begin
					code = CMD_LEVEL;
					arg = level_arg[g];
				end else if (pend[g].stepup) code = CMD_STEPUP;
				else if (pend[g].up) code = CMD_UP;
				else if (pend[g].down) code = CMD_DOWN;
				else if (pend[g].tcup) code = CMD_TCUP;
				else if (pend[g].tcdown) code = CMD_TCDOWN;
				else if (pend[g].scene) begin
					code = CMD_SCENE;
					arg = {4'd0, scene_arg[g]};
				end else if (pend[g].rest_cnt != 0) code = CMD_REST;
				else if (pend[g].relight_cnt != 0) code = CMD_RELIGHT;
				else if (pend[g].inhibit_cnt != 0) code = CMD_INHIBIT;
				else if (pend[g].query) begin
					code = CMD_QUERY;
					arg = query_arg[g];
				end else hit = 1'b0;
				if (hit && r.sink_ready) begin
					case (code)
						CMD_RMAX:    pend[g].rmax = 1'b0;
						CMD_OFF:     pend[g].off = 1'b0;
						CMD_LEVEL:   pend[g].lvl = 1'b0;
						CMD_STEPUP:  pend[g].stepup = 1'b0;
						CMD_UP:      pend[g].up = 1'b0;
						CMD_DOWN:    pend[g].down = 1'b0;
						CMD_TCUP:    pend[g].tcup = 1'b0;
						CMD_TCDOWN:  pend[g].tcdown = 1'b0;
						CMD_SCENE:   pend[g].scene = 1'b0;
						CMD_REST:    pend[g].rest_cnt = pend[g].rest_cnt - 2'd1;
						CMD_RELIGHT: pend[g].relight_cnt = pend[g].relight_cnt - 2'd1;
						CMD_INHIBIT: pend[g].inhibit_cnt = pend[g].inhibit_cnt - 2'd1;
						default:     pend[g].query = 1'b0;
					endcase
					cmd.cmd_valid = 1'b1;
					cmd.cmd_code = code;
					cmd.cmd_group = r.group;
					cmd.cmd_argument = arg;
				end
			end
			OP_RMAX: begin
				drop_motion(g);
				pend[g].off = 1'b0;
				pend[g].rmax = 1'b1;
			end
			OP_OFF: begin
				drop_motion(g);
				pend[g].rmax = 1'b0;
				pend[g].off = 1'b1;
			end
			OP_LEVEL: begin
				if (r.from_light_regulator) begin
					// A regulator level yields to motion and to off or recall-max.
					if (pend[g].up || pend[g].down || pend[g].rmax || pend[g].off)
						return cmd;
				end else begin
					drop_motion(g);
					pend[g].rmax = 1'b0;
					pend[g].off = 1'b0;
				end
				pend[g].lvl = 1'b1;
				level_arg[g] = r.level;
			end
			OP_STEPUP: pend[g].stepup = 1'b1;
			OP_UP: begin
				pend[g].down = 1'b0;
				pend[g].up = 1'b1;
			end
			OP_DOWN: begin
				pend[g].up = 1'b0;
				pend[g].down = 1'b1;
			end
			OP_TCUP: begin
				pend[g].tcdown = 1'b0;
				pend[g].tcup = 1'b1;
			end
			OP_TCDOWN: begin
				pend[g].tcup = 1'b0;
				pend[g].tcdown = 1'b1;
			end
			OP_SCENE: begin
				pend[g].scene = 1'b1;
				scene_arg[g] = r.scene_number;
			end
			OP_REST, OP_RELIGHT, OP_INHIBIT: begin
				pend[g].rest_cnt = (r.opcode == OP_REST) ? 2'd2 : 2'd0;
				pend[g].relight_cnt = (r.opcode == OP_RELIGHT) ? 2'd2 : 2'd0;
				pend[g].inhibit_cnt = (r.opcode == OP_INHIBIT) ? 2'd2 : 2'd0;
			end
			OP_QUERY: begin
				pend[g].query = 1'b1;
				query_arg[g] = r.sensor_address;
			end
			default: ;
		endcase
		return cmd;
	endfunction

	task automatic report(string what, rsp_t exp_cmd, rsp_t got_cmd);
		fails++;
		if (fails <= REPORT_LIMIT)
			$display(
				"%0t %s: valid/code/group/arg expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
				$realtime, what, exp_cmd.cmd_valid, exp_cmd.cmd_code, exp_cmd.cmd_group,
				exp_cmd.cmd_argument, got_cmd.cmd_valid, got_cmd.cmd_code, got_cmd.cmd_group,
				got_cmd.cmd_argument);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GROUP_COUNT; i++)
				pend[i] = '0;
			cmd_q.delete();
			fails = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// Results are checked before this edge's request is predicted, so a
			// result never pairs with a beat accepted at the same edge.
			if (done) begin
				if (cmd_q.size() == 0) begin
					report("result beat with nothing expected", '0, result);
				end else begin
					want = cmd_q.pop_front();
					if (result.cmd_valid !== want.cmd_valid || result.cmd_code !== want.cmd_code ||
					    result.cmd_group !== want.cmd_group ||
					    result.cmd_argument !== want.cmd_argument)
						report("result mismatch", want, result);
				end
			end
			if (start && !busy)
				cmd_q.push_back(schedule(request));
			mismatches <= fails;
			outstanding <= cmd_q.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: top level of the group pending command scheduler simulation
// Drives request beats into the scheduler, directed first and random after,
// with random gaps between beats, and lets a scoreboard beside the block
// predict and check every result beat. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module testbench import gpcs_pkg::*; ();

	// Upper bound on the whole run. It leaves a wide margin over what a correct
	// run needs, even at the longest gaps.
	localparam int CYCLE_LIMIT = 150000;
	localparam int RANDOM_BEATS = 1400;
	// Cycles to keep watching after the last expected result, to catch any
	// stray result beat.
	localparam int DRAIN_CYCLES = 8;
	// Opcode values that have no action. The block must ignore them.
	localparam logic [3:0] OP_SPARE_LO = 4'd14;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	int   mismatches;
	int   outstanding;
	int   cycles = 0;
	// While set, beats go back to back with no gaps at all.
	logic no_gaps = 1'b0;

	always #5 clk = ~clk;

	group_pending_command_scheduler_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	gpcs_scoreboard scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.done        (done),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Watchdog. A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic req_t make_req(logic [3:0] op, logic [3:0] grp, logic [7:0] lvl,
		logic [3:0] scn, logic [7:0] addr, logic reg_src, logic rdy);
		req_t r;
		r.opcode = op;
		r.group = grp;
		r.level = lvl;
		r.scene_number = scn;
		r.sensor_address = addr;
		r.from_light_regulator = reg_src;
		r.sink_ready = rdy;
		return r;
	endfunction

	// Random beat. Most beats land on a few groups so that pending commands
	// pile up, cancel each other and get drained by service beats; the rest
	// spread over all groups. About a third of the beats are service beats,
	// and a few of those find the sink not ready.
	function automatic req_t random_req();
		req_t r;
		int   pick;
		r = make_req(OP_SERVICE, 4'($urandom_range(0, 3)), 8'($urandom), 4'($urandom),
			8'($urandom), 1'($urandom), 1'b1);
		if ($urandom_range(0, 4) == 0)
			r.group = 4'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 35)
			r.sink_ready = ($urandom_range(0, 6) != 0);
		else if (pick < 37)
			r.opcode = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
		else begin
			r.opcode = 4'($urandom_range(OP_RMAX, OP_QUERY));
			r.sink_ready = 1'($urandom);
		end
		return r;
	endfunction

	// Presents one beat after a random gap and returns at the edge that takes
	// it. The gap and the raise of start fall on different edges, so start is
	// never lowered and raised within one time step.
	task automatic issue(req_t r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Holds the sender off until every predicted result has come back.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats. Group 0 collects one of every request, with the
		// conflicts between them, and is then serviced until empty; group 15
		// and the field extremes come along the way.
		issue(make_req(OP_SERVICE, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b1));     // nothing pending
		issue(make_req(OP_RMAX, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0));
		issue(make_req(OP_OFF, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0));         // cancels recall-max
		issue(make_req(OP_LEVEL, 4'd0, 8'hff, 4'd0, 8'd0, 1'b1, 1'b0));      // regulator, off pending
		issue(make_req(OP_LEVEL, 4'd15, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0));
		issue(make_req(OP_STEPUP, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0));
		issue(make_req(OP_UP, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0));
		issue(make_req(OP_DOWN, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0));        // cancels up
		issue(make_req(OP_TCUP, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0));
		issue(make_req(OP_TCDOWN, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0));      // cancels tc up
		issue(make_req(OP_SCENE, 4'd0, 8'd0, 4'hf, 8'd0, 1'b0, 1'b0));
		issue(make_req(OP_REST, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0));
		issue(make_req(OP_RELIGHT, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0));     // cancels rest
		issue(make_req(OP_INHIBIT, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0));     // cancels relight
		issue(make_req(OP_QUERY, 4'd0, 8'd0, 4'd0, 8'hff, 1'b0, 1'b0));
		issue(make_req(OP_SPARE_LO, 4'd0, 8'hff, 4'hf, 8'hff, 1'b1, 1'b1));
		issue(make_req(OP_SPARE_HI, 4'd15, 8'hff, 4'hf, 8'hff, 1'b1, 1'b1));
		issue(make_req(OP_SERVICE, 4'd0, 8'hff, 4'hf, 8'hff, 1'b1, 1'b0));   // sink not ready
		// Off, step up, down, tc down, scene, inhibit twice, query: eight
		// commands, then one more service that finds nothing left.
		repeat (9)
			issue(make_req(OP_SERVICE, 4'd0, 8'd0, 4'd0, 8'd0, 1'b0, 1'b1));
		issue(make_req(OP_SERVICE, 4'd15, 8'd0, 4'd0, 8'd0, 1'b0, 1'b1));
		settle();

		// Random beats. Every hundred beats the gap mode is redrawn, so some
		// stretches run back to back; now and then the sender waits for the
		// block to catch up completely.
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i % 100 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			issue(random_req());
			if (i % 350 == 349)
				settle();
		end
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- group_pending_command_scheduler_top.f -----
hdl/gpcs_pkg.sv
hdl/gpcs_select.sv
hdl/group_pending_command_scheduler_top.sv
sim/gpcs_scoreboard.sv
sim/testbench.sv
